// ===== rtl/core/nfid_pkg.sv =====
// Shared constants and types for the next-fit ID allocator.
`timescale 1ns / 1ps

package nfid_pkg;

   // Default number of IDs that the map can hold.
   localparam int POOL_MAX_DEF = 64;

   // The map is stored in rows of ROW_W marks; ROW_BW is log2 of that.
   localparam int ROW_W  = 8;
   localparam int ROW_BW = 3;

   // Fixed field widths of the ports.
   localparam int CSR_W    = 7;
   localparam int ID_W     = 6;
   localparam int STATUS_W = 2;

   // Pool size that reset selects before it is clamped to the map size.
   localparam int RESET_POOL = 64;

   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [ROW_W-1:0]    row_type;

   localparam status_type ST_GRANTED = 2'd0;
   localparam status_type ST_FULL    = 2'd1;
   localparam status_type ST_FREED   = 2'd2;
   localparam status_type ST_BADFREE = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

endpackage

// ===== rtl/core/next_fit_id_allocator.sv =====
// Top level of the next-fit ID allocator: request/response channels, map RAM, search sequencer.
`timescale 1ns / 1ps

// Next-fit ID allocator.
// A request word on the req_ channel either allocates an ID (req_op allocate) or releases
// req_free_id (req_op free). Every request gives exactly one response word on the rsp_
// channel: granted with the ID, pool full, freed, or bad free. An allocation searches from
// the next-search pointer to the end of the active pool, wraps to zero, and takes the first
// free ID; the pointer then moves to the ID after it.
// The in-use marks live in a RAM of eight marks per row. A free request reads the row of its
// ID and registers its response word once the output register is free. An allocation visits
// one row per cycle and registers its response word, again once the output register is free,
// when it finds a free ID or has searched the whole pool. One request is worked on at a time.
// The response sits in an output register, so the next request is accepted while an
// earlier response still waits on a stalled receiver. If the receiver stalls while a second
// result is ready, the sequencer holds that result without touching the map until the
// output register drains.
// Writing csr_wdata (the pool size) starts a new pool: all marks read as free and the
// pointer returns to zero. Reset does the same with a pool size of 64. Per-row valid bits
// give the cleared state at once, so there is no clearing pass after reset.
module next_fit_id_allocator #(
   parameter int POOL_MAX = nfid_pkg::POOL_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [nfid_pkg::ID_W-1:0]     req_free_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output nfid_pkg::status_type          rsp_status,
   output logic [nfid_pkg::ID_W-1:0]     rsp_granted_id,
   input  logic                          csr_we,
   input  logic [nfid_pkg::CSR_W-1:0]    csr_wdata
);

   import nfid_pkg::*;

   // Geometry of the map RAM.
   localparam int NROWS     = (POOL_MAX + ROW_W - 1) / ROW_W;
   localparam int RW        = (NROWS > 1) ? $clog2(NROWS) : 1;
   localparam int NROWS_MEM = 1 << RW;
   localparam int IXW       = RW + ROW_BW;
   localparam int SZW       = $clog2(POOL_MAX + 1);
   // Common width for comparisons of IDs, sizes and register values.
   localparam int WW        = ((IXW > CSR_W) ? IXW : CSR_W) + 1;
   localparam int RST_SIZE  = (POOL_MAX < RESET_POOL) ? POOL_MAX : RESET_POOL;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EVAL = 1'b1;

   logic                 state_ff, state_in;
   logic [RW-1:0]        row_ff, row_in;
   logic                 phase_ff, phase_in;
   logic [IXW-1:0]       ptr_ff, ptr_in;
   logic [SZW-1:0]       size_ff, size_in;
   logic [NROWS_MEM-1:0] rv_ff, rv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [ID_W-1:0]      gid_ff, gid_in;
   logic                 op_ff;
   logic [ID_W-1:0]      fid_ff;

   // RAM port signals.
   logic                 ram_we, ram_re;
   logic [RW-1:0]        ram_raddr;
   row_type              ram_wdata, ram_q;

   // Search and check signals.
   row_type              q_eff;
   row_type              elig;
   logic                 found;
   logic [ROW_BW-1:0]    fb;
   logic [WW-1:0]        size_w, start_w, fid_w, gid_w, nid_w;
   logic [IXW-1:0]       start_ix, gid_ix;
   logic [RW-1:0]        start_row, last_row, fid_row;
   logic [SZW-1:0]       size_m1, size_clamp;
   logic                 free_ok;
   logic                 out_free;

   nfid_ram #(
      .WIDTH(ROW_W),
      .DEPTH(NROWS_MEM)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(row_ff),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_q)
   );

   // A row that was never written since the last pool start reads as all free.
   assign q_eff = rv_ff[row_ff] ? ram_q : '0;

   assign size_w    = WW'(size_ff);
   // The pointer is kept inside the pool, but a stale pointer still starts at zero.
   assign start_ix  = (WW'(ptr_ff) < size_w) ? ptr_ff : '0;
   assign start_w   = WW'(start_ix);
   assign start_row = start_ix[IXW-1:ROW_BW];
   assign size_m1   = size_ff - SZW'(1);
   assign last_row  = RW'(WW'(size_m1) >> ROW_BW);
   assign fid_w     = WW'(fid_ff);
   assign fid_row   = RW'(WW'(req_free_id) >> ROW_BW);
   assign free_ok   = (fid_w < size_w) && q_eff[fid_ff[ROW_BW-1:0]];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // The clamped pool size taken from a register write.
   always_comb begin
      if (csr_wdata == '0) begin
         size_clamp = SZW'(1);
      end else if (WW'(csr_wdata) > WW'(POOL_MAX)) begin
         size_clamp = SZW'(POOL_MAX);
      end else begin
         size_clamp = SZW'(csr_wdata);
      end
   end

   // Free marks of the current row that this pass of the search may take.
   always_comb begin
      logic [WW-1:0] idw;
      for (int b = 0; b < ROW_W; b++) begin
         idw     = WW'({row_ff, ROW_BW'(b)});
         elig[b] = !q_eff[b] && (idw < size_w) &&
                   (phase_ff ? (idw < start_w) : (idw >= start_w));
      end
   end

   // Lowest eligible mark of the row.
   always_comb begin
      fb = '0;
      for (int b = ROW_W - 1; b >= 0; b--) begin
         if (elig[b]) begin
            fb = ROW_BW'(b);
         end
      end
   end

   assign found  = |elig;
   assign gid_ix = {row_ff, fb};
   assign gid_w  = WW'(gid_ix);
   assign nid_w  = gid_w + WW'(1);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      phase_in     = phase_ff;
      ptr_in       = ptr_ff;
      size_in      = size_ff;
      rv_in        = rv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      gid_in       = gid_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = row_ff;
      ram_wdata    = q_eff;

      case (state_ff)
         S_IDLE: begin
            if (csr_we) begin
               size_in = size_clamp;
               ptr_in  = '0;
               rv_in   = '0;
            end
            if (req_valid) begin
               // Start the read of the first row this request needs.
               ram_re   = 1'b1;
               phase_in = 1'b0;
               state_in = S_EVAL;
               row_in   = (req_op == OP_FREE) ? fid_row : start_row;
               ram_raddr = row_in;
            end
         end
         S_EVAL: begin
            if (op_ff == OP_FREE) begin
               if (out_free) begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
                  gid_in       = '0;
                  status_in    = free_ok ? ST_FREED : ST_BADFREE;
                  if (free_ok) begin
                     ram_we = 1'b1;
                     ram_wdata = q_eff & ~(row_type'(1) << fid_ff[ROW_BW-1:0]);
                     rv_in[row_ff] = 1'b1;
                  end
               end
            end else if (found) begin
               if (out_free) begin
                  state_in      = S_IDLE;
                  rsp_valid_in  = 1'b1;
                  status_in     = ST_GRANTED;
                  gid_in        = gid_w[ID_W-1:0];
                  ram_we        = 1'b1;
                  ram_wdata     = q_eff | (row_type'(1) << fb);
                  rv_in[row_ff] = 1'b1;
                  ptr_in        = (nid_w < size_w) ? nid_w[IXW-1:0] : '0;
               end
            end else if (!phase_ff && (row_ff != last_row)) begin
               // Next row of the pass from the pointer to the end of the pool.
               row_in    = row_ff + RW'(1);
               ram_re    = 1'b1;
               ram_raddr = row_in;
            end else if (!phase_ff && (start_ix != '0)) begin
               // Wrap to zero and search the IDs below the pointer.
               phase_in  = 1'b1;
               row_in    = '0;
               ram_re    = 1'b1;
               ram_raddr = row_in;
            end else if (phase_ff && (row_ff != start_row)) begin
               row_in    = row_ff + RW'(1);
               ram_re    = 1'b1;
               ram_raddr = row_in;
            end else if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = ST_FULL;
               gid_in       = '0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= 1'b0;
         ptr_ff       <= '0;
         size_ff      <= SZW'(RST_SIZE);
         rv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         ptr_ff       <= ptr_in;
         size_ff      <= size_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      status_ff <= status_in;
      gid_ff    <= gid_in;
      if (state_ff == S_IDLE && req_valid) begin
         op_ff  <= req_op;
         fid_ff <= req_free_id;
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_granted_id = gid_ff;

   // The map is only written when a request finishes its check.
   a_write_in_eval: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_EVAL))
      else $error("map written outside of a request");

   // The search pointer always stays inside the active pool.
   a_ptr_in_pool: assert property (@(posedge clock) disable iff (reset)
      WW'(ptr_ff) < size_w)
      else $error("search pointer outside the pool");

   // A grant takes a mark that was free.
   a_grant_free_mark: assert property (@(posedge clock) disable iff (reset)
      (ram_we && op_ff == OP_ALLOC) |-> !q_eff[fb])
      else $error("granted an ID that was in use");

   // A finished request leaves a response word behind.
   a_finish_gives_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("request finished without a response");

endmodule

// ===== rtl/core/nfid_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module nfid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb_next_fit_id_allocator.sv =====
// Self-checking testbench for the next-fit ID allocator: directed table, then random phases.
`timescale 1ns / 1ps

// The run starts with a short table of request words that walks the corner cases: the
// first grants after reset, frees of IDs that were never granted or lie past the pool,
// a pool of one ID, pool sizes of zero and above the map size, and a small pool that
// fills up and wraps. Rows whose response is obvious carry it typed in. All other rows,
// and the random phases that follow, are checked against a predictor kept in this file.
// Each random phase writes a fresh pool size while the block is idle and then sends a
// mix of allocations and frees. Most frees name an ID that is currently granted, so the
// map really fills and drains. The rest are random IDs, which give bad frees unless granted.
// Both channels stall at random, and once the receiver holds off for a long stretch so
// that the block backs up and stops taking request words.
module tb_next_fit_id_allocator;
   import nfid_pkg::*;

   localparam int MAP_IDS     = POOL_MAX_DEF;
   localparam int RANDOM_WORDS = 1550;
   localparam int HOLD_AT     = 400;   // response count at which the long hold begins
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;
   localparam int RSP_SLOTS   = 16;    // expected responses that can be outstanding
   localparam int ROW_SLOTS   = 64;    // room in the directed table

   typedef enum bit {ROW_WORD, ROW_POOL} row_kind_type;

   // One row of the directed table. For pool rows, value is the pool size; for request
   // words its low bits are the free ID.
   typedef struct {
      row_kind_type kind;
      logic         op;
      logic [6:0]   value;
      bit           typed;
      status_type   status;
      logic [5:0]   gid;
   } stim_row_type;

   typedef struct {
      status_type status;
      logic [5:0] gid;
   } rsp_word_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_op;
   logic [ID_W-1:0]     req_free_id;
   logic                rsp_valid;
   logic                rsp_ready;
   status_type          rsp_status;
   logic [ID_W-1:0]     rsp_granted_id;
   logic                csr_we;
   logic [CSR_W-1:0]    csr_wdata;

   // Predictor state: one busy mark per ID, the search pointer and the pool register.
   bit [MAP_IDS-1:0]    id_busy;
   int                  search_ptr;
   logic [CSR_W-1:0]    pool_reg;

   // Expected responses in a ring, filled on acceptance and drained by the receiver.
   rsp_word_type        pending_rsp[RSP_SLOTS];
   int                  rsp_wr_count;
   int                  rsp_rd_count;
   stim_row_type        stim_rows[ROW_SLOTS];
   int                  stim_count;

   int                  mismatches;
   int                  sent_words;
   int                  got_words;
   int                  pool_writes;
   int                  seen_status[4];
   bit                  calm;          // when set, neither side takes random gaps
   int                  longest_hold;

   next_fit_id_allocator u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_free_id    (req_free_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_granted_id (rsp_granted_id),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   // Number of expected responses that the receiver has not taken yet.
   function automatic int outstanding();
      return rsp_wr_count - rsp_rd_count;
   endfunction

   // A zero pool size acts as one ID; anything above the map size saturates.
   function automatic int clamp_pool(logic [CSR_W-1:0] v);
      if (v == 0) begin
         return 1;
      end
      if (int'(v) > MAP_IDS) begin
         return MAP_IDS;
      end
      return int'(v);
   endfunction

   // Works out the response to one accepted request word and updates the predictor.
   function automatic rsp_word_type predict_response(logic op, logic [5:0] id);
      rsp_word_type w;
      int           size;
      int           start;
      int           slot;
      bit           found;
      size  = clamp_pool(pool_reg);
      w.status = ST_FULL;
      w.gid    = '0;
      if (op == OP_ALLOC) begin
         start = (search_ptr < size) ? search_ptr : 0;
         found = 1'b0;
         for (int k = 0; k < size; k++) begin
            slot = start + k;
            if (slot >= size) begin
               slot -= size;
            end
            if (!found && !id_busy[slot]) begin
               found         = 1'b1;
               id_busy[slot] = 1'b1;
               search_ptr    = (slot + 1 < size) ? slot + 1 : 0;
               w.status      = ST_GRANTED;
               w.gid         = slot[5:0];
            end
         end
      end else if (int'(id) < size && id_busy[id]) begin
         id_busy[id] = 1'b0;
         w.status    = ST_FREED;
      end else begin
         w.status = ST_BADFREE;
      end
      return w;
   endfunction

   // Picks an ID that is granted right now, or any ID of the pool if none is.
   function automatic logic [5:0] pick_busy();
      int         size;
      int         first;
      int         slot;
      bit         found;
      logic [5:0] pick;
      size  = clamp_pool(pool_reg);
      first = $urandom_range(0, size - 1);
      pick  = first[5:0];
      found = 1'b0;
      for (int k = 0; k < size; k++) begin
         slot = (first + k) % size;
         if (!found && id_busy[slot]) begin
            found = 1'b1;
            pick  = slot[5:0];
         end
      end
      return pick;
   endfunction

   // Idle length shared by both sides: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic void flag_error(string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: mismatch: %s", $time, what);
      end
   endfunction

   function automatic void add_row(row_kind_type kind, logic op, logic [6:0] value, bit typed,
                                   status_type status, logic [5:0] gid);
      stim_row_type row;
      row.kind   = kind;
      row.op     = op;
      row.value  = value;
      row.typed  = typed;
      row.status = status;
      row.gid    = gid;
      stim_rows[stim_count] = row;
      stim_count++;
   endfunction

   // Offers one request word after a random gap and holds it until it is taken. Valid is
   // left high on return, so a following word with no gap keeps it up without a glitch.
   // A typed response, where given, is queued instead of the predicted one; the
   // predictor still runs so that its map stays in step.
   task automatic send_word(logic op, logic [5:0] id, bit typed, status_type status,
                            logic [5:0] gid);
      int           gap;
      rsp_word_type w;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_free_id <= id;
      do @(posedge clock); while (!req_ready);
      w = predict_response(op, id);
      if (typed) begin
         w.status = status;
         w.gid    = gid;
      end
      pending_rsp[rsp_wr_count % RSP_SLOTS] = w;
      rsp_wr_count++;
      sent_words++;
   endtask

   // Writes a new pool size once the block has answered everything. The write clears the
   // map and the pointer, so the predictor starts over as well.
   task automatic set_pool(logic [CSR_W-1:0] size);
      req_valid <= 1'b0;
      while (outstanding() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      csr_we     <= 1'b0;
      pool_reg   = size;
      id_busy    = '0;
      search_ptr = 0;
      pool_writes++;
   endtask

   // Receiver: checks every word it takes against the oldest expected response and
   // drives rsp_ready with random stalls, plus one long hold in the middle of the run.
   initial begin : receiver
      rsp_word_type want;
      int           stall_left;
      bit           hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      rsp_ready  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got_words++;
            if (outstanding() == 0) begin
               flag_error($sformatf("unexpected word, status %0d id %0d",
                                    rsp_status, rsp_granted_id));
            end else begin
               want = pending_rsp[rsp_rd_count % RSP_SLOTS];
               rsp_rd_count++;
               seen_status[int'(want.status)]++;
               if (rsp_status !== want.status || rsp_granted_id !== want.gid) begin
                  flag_error($sformatf("status %0d id %0d, wanted status %0d id %0d",
                                       rsp_status, rsp_granted_id, want.status, want.gid));
               end
            end
            stall_left = pick_gap();
         end
         if (!hold_done && got_words >= HOLD_AT) begin
            hold_done    = 1'b1;
            stall_left   = HOLD_CYCLES;
            longest_hold = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Sender and run control.
   initial begin : stimulus
      int          random_words;
      int          alloc_pct;
      int          phase_len;
      int          r;
      logic        op;
      logic [5:0]  id;
      logic [6:0]  size;
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_op      = OP_ALLOC;
      req_free_id = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      calm        = 1'b0;
      mismatches  = 0;
      sent_words  = 0;
      got_words   = 0;
      pool_writes = 0;
      longest_hold = 0;
      seen_status = '{default: 0};
      pool_reg    = CSR_W'(RESET_POOL);
      id_busy     = '0;
      search_ptr  = 0;
      random_words = 0;
      rsp_wr_count = 0;
      rsp_rd_count = 0;
      stim_count   = 0;

      // After reset the pool holds 64 IDs and the search starts at zero.
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  1, ST_GRANTED, 6'd0);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  1, ST_GRANTED, 6'd1);
      add_row(ROW_WORD, OP_FREE,  7'd0,  1, ST_FREED,   6'd0);
      add_row(ROW_WORD, OP_FREE,  7'd0,  1, ST_BADFREE, 6'd0);  // already released
      add_row(ROW_WORD, OP_FREE,  7'd63, 1, ST_BADFREE, 6'd0);  // never granted
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  0, ST_GRANTED, 6'd0);  // next fit skips free ID 0
      // A pool of one ID fills at once; ID 1 lies past its end.
      add_row(ROW_POOL, OP_ALLOC, 7'd1,  0, ST_GRANTED, 6'd0);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  1, ST_GRANTED, 6'd0);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  1, ST_FULL,    6'd0);
      add_row(ROW_WORD, OP_FREE,  7'd1,  1, ST_BADFREE, 6'd0);
      add_row(ROW_WORD, OP_FREE,  7'd0,  1, ST_FREED,   6'd0);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  1, ST_GRANTED, 6'd0);
      // A pool size of zero behaves as a pool of one.
      add_row(ROW_POOL, OP_ALLOC, 7'd0,  0, ST_GRANTED, 6'd0);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  1, ST_GRANTED, 6'd0);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  1, ST_FULL,    6'd0);
      add_row(ROW_WORD, OP_FREE,  7'd1,  1, ST_BADFREE, 6'd0);
      // The largest register value saturates to the full map.
      add_row(ROW_POOL, OP_ALLOC, 7'd127, 0, ST_GRANTED, 6'd0);
      add_row(ROW_WORD, OP_FREE,  7'd63, 1, ST_BADFREE, 6'd0);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  1, ST_GRANTED, 6'd0);
      // Three IDs: fill, report full, then free and regrant across the wrap.
      add_row(ROW_POOL, OP_ALLOC, 7'd3,  0, ST_GRANTED, 6'd0);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  1, ST_GRANTED, 6'd0);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  1, ST_GRANTED, 6'd1);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  1, ST_GRANTED, 6'd2);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  1, ST_FULL,    6'd0);
      add_row(ROW_WORD, OP_FREE,  7'd1,  1, ST_FREED,   6'd0);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  0, ST_GRANTED, 6'd0);
      add_row(ROW_WORD, OP_FREE,  7'd2,  1, ST_FREED,   6'd0);
      add_row(ROW_WORD, OP_ALLOC, 7'd0,  0, ST_GRANTED, 6'd0);
      add_row(ROW_WORD, OP_FREE,  7'd3,  1, ST_BADFREE, 6'd0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < stim_count; i++) begin
         if (stim_rows[i].kind == ROW_POOL) begin
            set_pool(stim_rows[i].value);
         end else begin
            send_word(stim_rows[i].op, stim_rows[i].value[5:0], stim_rows[i].typed,
                      stim_rows[i].status, stim_rows[i].gid);
         end
      end

      // Random phases. Small pools dominate so that full pools and wraps come often;
      // the full map, zero and oversized settings still turn up regularly.
      while (random_words < RANDOM_WORDS) begin
         r = $urandom_range(0, 9);
         if (r < 4) begin
            size = 7'($urandom_range(1, 8));
         end else if (r < 6) begin
            size = 7'($urandom_range(9, 63));
         end else if (r < 8) begin
            size = 7'd64;
         end else if (r < 9) begin
            size = 7'($urandom_range(65, 127));
         end else begin
            size = 7'd0;
         end
         set_pool(size);
         calm      = ($urandom_range(0, 3) == 0);
         alloc_pct = 30 + 20 * $urandom_range(0, 3);
         phase_len = $urandom_range(40, 160);
         repeat (phase_len) begin
            id = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 99) < alloc_pct) begin
               op = OP_ALLOC;
            end else begin
               op = OP_FREE;
               if ($urandom_range(0, 99) < 75) begin
                  id = pick_busy();
               end
            end
            send_word(op, id, 0, ST_GRANTED, 6'd0);
            random_words++;
         end
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      while (outstanding() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d request words over %0d pool settings; %0d responses taken.",
               sent_words, pool_writes, got_words);
      $display("Granted %0d, full %0d, freed %0d, bad free %0d; receiver hold of %0d cycles.",
               seen_status[ST_GRANTED], seen_status[ST_FULL], seen_status[ST_FREED],
               seen_status[ST_BADFREE], longest_hold);
      if (mismatches == 0 && outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d responses still outstanding.",
                  mismatches, outstanding());
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, including every stall at its longest.
   initial begin : watchdog
      #20_000_000;
      $display("Timeout with %0d responses outstanding.", outstanding());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
